/* design/aps_pkg.sv */
// Shared widths, reset values, register indexes, sequencer states and the
// multiplier request type for the adaptive power squelch.
// No dependencies.
`default_nettype none

package aps_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int POWER_W    = 32;
   localparam int RATIO_W    = 8;
   localparam int ALPHA_W    = 16;
   localparam int SUM_W      = 44;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam int MUL_A_W    = 32;
   localparam int MUL_B_W    = 16;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   localparam int DIV_STEPS  = SUM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int ALPHA_SHIFT = 16;

   localparam int MAX_BLOCK_DEFAULT = 4096;

   localparam logic [RATIO_W-1:0] RATIO_RESET = 8'd80;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd655;
   localparam logic [POWER_W-1:0] FLOOR_RESET = 32'd10737;

   localparam logic [CSR_IDX_W-1:0] REG_SQUELCH_RATIO     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_ALPHA       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOISE_FLOOR_START = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_I,
      ST_SQ_Q,
      ST_ACC,
      ST_DIV,
      ST_SCALE,
      ST_CMP,
      ST_ADAPT,
      ST_OUT
   } aps_state_type;

   typedef struct packed {
      logic               load;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } aps_mul_req_type;

endpackage

`default_nettype wire

/* design/aps_if.sv */
// Valid/ready channel interfaces for sample items, result items and
// register writes. Depends on aps_pkg.
`default_nettype none

interface aps_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [aps_pkg::SAMPLE_W-1:0] i_sample;
   logic signed [aps_pkg::SAMPLE_W-1:0] q_sample;
   logic                                last_of_block;

   modport source (output valid, i_sample, q_sample, last_of_block, input ready);
   modport sink   (input valid, i_sample, q_sample, last_of_block, output ready);
endinterface

interface aps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         squelch_open;
   logic                         modem_reset;
   logic [aps_pkg::POWER_W-1:0]  block_power;
   logic [aps_pkg::POWER_W-1:0]  noise_floor;

   modport source (output valid, squelch_open, modem_reset, block_power, noise_floor,
                   input ready);
   modport sink   (input valid, squelch_open, modem_reset, block_power, noise_floor,
                   output ready);
endinterface

interface aps_csr_if;
   logic                             valid;
   logic                             ready;
   logic [aps_pkg::CSR_IDX_W-1:0]    reg_index;
   logic [aps_pkg::CSR_DATA_W-1:0]   wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* design/adaptive_power_squelch.sv */
// Top level: power accumulation, block mean divide and noise floor tracking.
// Depends on aps_pkg, aps_if and aps_mul.
// Sequence: a sample that does not close a block occupies the block through accept,
// two squares through the shared multiplier and accumulate. A closing sample then
// runs the bit-serial divide and scale/compare/adapt/output, skipping adapt if the
// squelch opens, and output waits for the result register. One item in flight.
// Reset (synchronous): registers to defaults, floor to its start value, sums cleared.
`default_nettype none

module adaptive_power_squelch #(
   parameter int MAX_BLOCK = aps_pkg::MAX_BLOCK_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   aps_req_if.sink   req_ch,
   aps_rsp_if.source rsp_ch,
   aps_csr_if.sink   csr_ch
);

   localparam int CW = $clog2(MAX_BLOCK + 1);

   aps_pkg::aps_state_type state_ff, state_in;
   aps_pkg::aps_mul_req_type mul_req;
   logic [aps_pkg::MUL_P_W-1:0] product;

   logic [aps_pkg::SAMPLE_W-1:0] i_mag_ff, i_mag_in;
   logic [aps_pkg::SAMPLE_W-1:0] q_mag_ff, q_mag_in;
   logic                         last_ff, last_in;
   logic [aps_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [CW:0]                  rem_ff, rem_in;
   logic [aps_pkg::DIV_CNT_W-1:0] step_ff, step_in;
   logic [aps_pkg::POWER_W-1:0]  power_ff, power_in;
   logic [aps_pkg::POWER_W-1:0]  noise_ff, noise_in;
   logic                         dirty_ff, dirty_in;
   logic                         open_ff, open_in;
   logic                         mreset_ff, mreset_in;
   logic [aps_pkg::RATIO_W-1:0]  ratio_ff, ratio_in;
   logic [aps_pkg::ALPHA_W-1:0]  alpha_ff, alpha_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_open_ff, rsp_open_in;
   logic                         rsp_mreset_ff, rsp_mreset_in;
   logic [aps_pkg::POWER_W-1:0]  rsp_power_ff, rsp_power_in;
   logic [aps_pkg::POWER_W-1:0]  rsp_noise_ff, rsp_noise_in;

   logic                         req_fire;
   logic                         out_free;
   logic [aps_pkg::SUM_W:0]      sum_add;
   logic [aps_pkg::SUM_W-1:0]    sum_sat;
   logic [CW-1:0]                count_next;
   logic                         block_close;
   logic [CW:0]                  rem_shift;
   logic                         div_ge;
   logic                         div_done;
   logic                         loud;
   logic                         floor_up;
   logic [aps_pkg::POWER_W-1:0]  diff;
   logic [aps_pkg::POWER_W:0]    up_sum;
   logic [aps_pkg::MUL_P_W:0]    dn_round;
   logic [aps_pkg::POWER_W:0]    dn_delta;
   logic [aps_pkg::POWER_W-1:0]  adapted;

   aps_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .product (product)
   );

   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Shared datapath terms
   always_comb begin
      sum_add = {1'b0, sum_ff} + (aps_pkg::SUM_W + 1)'(product[2*aps_pkg::SAMPLE_W-1:0]);
      sum_sat = sum_add[aps_pkg::SUM_W] ? '1 : sum_add[aps_pkg::SUM_W-1:0];

      count_next  = count_ff + 1'b1;
      block_close = last_ff || (count_next == CW'(MAX_BLOCK));

      rem_shift = {rem_ff[CW-1:0], sum_ff[aps_pkg::SUM_W-1]};
      div_ge    = rem_shift >= {1'b0, count_ff};
      div_done  = step_ff == aps_pkg::DIV_CNT_W'(aps_pkg::DIV_STEPS - 1);

      loud = aps_pkg::MUL_P_W'({power_ff, 4'b0000}) > product;

      floor_up = power_ff >= noise_ff;
      diff     = floor_up ? (power_ff - noise_ff) : (noise_ff - power_ff);

      up_sum   = {1'b0, noise_ff}
               + {1'b0, product[aps_pkg::MUL_P_W-1:aps_pkg::ALPHA_SHIFT]};
      dn_round = {1'b0, product} + (aps_pkg::MUL_P_W + 1)'((1 << aps_pkg::ALPHA_SHIFT) - 1);
      dn_delta = dn_round[aps_pkg::MUL_P_W:aps_pkg::ALPHA_SHIFT];

      if (floor_up) begin
         adapted = up_sum[aps_pkg::POWER_W] ? '1 : up_sum[aps_pkg::POWER_W-1:0];
      end else if (dn_delta >= {1'b0, noise_ff}) begin
         adapted = '0;
      end else begin
         adapted = noise_ff - dn_delta[aps_pkg::POWER_W-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         aps_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = aps_pkg::ST_SQ_I;
            end
         end
         aps_pkg::ST_SQ_I:  state_in = aps_pkg::ST_SQ_Q;
         aps_pkg::ST_SQ_Q:  state_in = aps_pkg::ST_ACC;
         aps_pkg::ST_ACC:   state_in = block_close ? aps_pkg::ST_DIV : aps_pkg::ST_IDLE;
         aps_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = aps_pkg::ST_SCALE;
            end
         end
         aps_pkg::ST_SCALE: state_in = aps_pkg::ST_CMP;
         aps_pkg::ST_CMP:   state_in = loud ? aps_pkg::ST_OUT : aps_pkg::ST_ADAPT;
         aps_pkg::ST_ADAPT: state_in = aps_pkg::ST_OUT;
         aps_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = aps_pkg::ST_IDLE;
            end
         end
         default:           state_in = aps_pkg::ST_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mul_req      = '0;
      case (state_ff)
         aps_pkg::ST_IDLE:  req_ch.ready = 1'b1;
         aps_pkg::ST_SQ_I: begin
            mul_req.load = 1'b1;
            mul_req.a    = aps_pkg::MUL_A_W'(i_mag_ff);
            mul_req.b    = i_mag_ff;
         end
         aps_pkg::ST_SQ_Q: begin
            mul_req.load = 1'b1;
            mul_req.a    = aps_pkg::MUL_A_W'(q_mag_ff);
            mul_req.b    = q_mag_ff;
         end
         aps_pkg::ST_SCALE: begin
            mul_req.load = 1'b1;
            mul_req.a    = noise_ff;
            mul_req.b    = aps_pkg::MUL_B_W'(ratio_ff);
         end
         aps_pkg::ST_CMP: begin
            mul_req.load = 1'b1;
            mul_req.a    = diff;
            mul_req.b    = alpha_ff;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // Datapath and register file
   always_comb begin
      i_mag_in  = i_mag_ff;
      q_mag_in  = q_mag_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      rem_in    = rem_ff;
      step_in   = step_ff;
      power_in  = power_ff;
      noise_in  = noise_ff;
      dirty_in  = dirty_ff;
      open_in   = open_ff;
      mreset_in = mreset_ff;
      ratio_in  = ratio_ff;
      alpha_in  = alpha_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_open_in   = rsp_open_ff;
      rsp_mreset_in = rsp_mreset_ff;
      rsp_power_in  = rsp_power_ff;
      rsp_noise_in  = rsp_noise_ff;

      case (state_ff)
         aps_pkg::ST_IDLE: begin
            if (req_fire) begin
               i_mag_in = req_ch.i_sample[aps_pkg::SAMPLE_W-1] ?
                          (~req_ch.i_sample + 1'b1) : req_ch.i_sample;
               q_mag_in = req_ch.q_sample[aps_pkg::SAMPLE_W-1] ?
                          (~req_ch.q_sample + 1'b1) : req_ch.q_sample;
               last_in  = req_ch.last_of_block;
            end
         end
         aps_pkg::ST_SQ_Q: begin
            sum_in = sum_sat;
         end
         aps_pkg::ST_ACC: begin
            sum_in   = sum_sat;
            count_in = count_next;
            rem_in   = '0;
            step_in  = '0;
         end
         aps_pkg::ST_DIV: begin
            rem_in  = div_ge ? (rem_shift - {1'b0, count_ff}) : rem_shift;
            sum_in  = {sum_ff[aps_pkg::SUM_W-2:0], div_ge};
            step_in = step_ff + 1'b1;
         end
         aps_pkg::ST_SCALE: begin
            power_in = (|sum_ff[aps_pkg::SUM_W-1:aps_pkg::POWER_W]) ?
                       '1 : sum_ff[aps_pkg::POWER_W-1:0];
         end
         aps_pkg::ST_CMP: begin
            open_in = loud;
            if (loud) begin
               dirty_in  = 1'b1;
               mreset_in = 1'b0;
            end
         end
         aps_pkg::ST_ADAPT: begin
            noise_in  = adapted;
            mreset_in = dirty_ff;
            dirty_in  = 1'b0;
         end
         aps_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_open_in   = open_ff;
               rsp_mreset_in = mreset_ff;
               rsp_power_in  = power_ff;
               rsp_noise_in  = noise_ff;
               sum_in        = '0;
               count_in      = '0;
            end
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase

      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.reg_index)
            aps_pkg::REG_SQUELCH_RATIO:
               ratio_in = csr_ch.wdata[aps_pkg::RATIO_W-1:0];
            aps_pkg::REG_NOISE_ALPHA:
               alpha_in = csr_ch.wdata[aps_pkg::ALPHA_W-1:0];
            aps_pkg::REG_NOISE_FLOOR_START:
               noise_in = csr_ch.wdata[aps_pkg::POWER_W-1:0];
            default: begin
               ratio_in = ratio_ff;
            end
         endcase
      end
   end

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aps_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         noise_ff     <= aps_pkg::FLOOR_RESET;
         dirty_ff     <= 1'b0;
         ratio_ff     <= aps_pkg::RATIO_RESET;
         alpha_ff     <= aps_pkg::ALPHA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         noise_ff     <= noise_in;
         dirty_ff     <= dirty_in;
         ratio_ff     <= ratio_in;
         alpha_ff     <= alpha_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_mag_ff      <= i_mag_in;
      q_mag_ff      <= q_mag_in;
      last_ff       <= last_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      power_ff      <= power_in;
      open_ff       <= open_in;
      mreset_ff     <= mreset_in;
      rsp_open_ff   <= rsp_open_in;
      rsp_mreset_ff <= rsp_mreset_in;
      rsp_power_ff  <= rsp_power_in;
      rsp_noise_ff  <= rsp_noise_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.squelch_open = rsp_open_ff;
   assign rsp_ch.modem_reset  = rsp_mreset_ff;
   assign rsp_ch.block_power  = rsp_power_ff;
   assign rsp_ch.noise_floor  = rsp_noise_ff;

endmodule

`default_nettype wire

/* design/aps_mul.sv */
// Shared unsigned multiplier with a registered product, used for the
// squares, the threshold scale and the floor adaptation. Depends on aps_pkg.
`default_nettype none

module aps_mul (
   input  wire logic                          clock,
   input  wire aps_pkg::aps_mul_req_type      mul_req,
   output logic [aps_pkg::MUL_P_W-1:0]        product
);

   logic [aps_pkg::MUL_P_W-1:0] product_ff;
   logic [aps_pkg::MUL_P_W-1:0] product_in;

   always_comb begin
      product_in = aps_pkg::MUL_P_W'(mul_req.a) * aps_pkg::MUL_P_W'(mul_req.b);
   end

   always_ff @(posedge clock) begin
      if (mul_req.load) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

/* tb/aps_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the adaptive power squelch: tracks register writes, predicts one
// verdict per closed block from accepted samples and compares it with each result.
// Depends on aps_pkg and aps_if.

module aps_checker #(
   parameter int MAX_BLOCK = aps_pkg::MAX_BLOCK_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   aps_req_if        req_ch,
   aps_rsp_if        rsp_ch,
   aps_csr_if        csr_ch,
   output int        fail_count,
   output int        pending
);

   import aps_pkg::*;

   localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 64'd1;

   typedef struct packed {
      logic               squelch_open;
      logic               modem_reset;
      logic [POWER_W-1:0] block_power;
      logic [POWER_W-1:0] noise_floor;
   } squelch_verdict_t;

   logic [RATIO_W-1:0] ratio_q;
   logic [ALPHA_W-1:0] alpha_q;
   logic [POWER_W-1:0] floor_q;
   logic [SUM_W-1:0]   sum_q;
   int unsigned        count_q;
   logic               dirty_q;
   squelch_verdict_t   verdict_q[$];

   function automatic logic [POWER_W-1:0] track_floor(logic [POWER_W-1:0] noise,
                                                      logic [POWER_W-1:0] power,
                                                      logic [ALPHA_W-1:0] alpha);
      logic [63:0] step;
      logic [63:0] raised;
      if (power >= noise) begin
         step   = (64'(power - noise) * 64'(alpha)) >> ALPHA_SHIFT;
         raised = 64'(noise) + step;
         return (raised > 64'hFFFF_FFFF) ? '1 : raised[POWER_W-1:0];
      end
      // round the downward step away from zero
      step = (64'(noise - power) * 64'(alpha) + 64'd65535) >> ALPHA_SHIFT;
      return (step >= 64'(noise)) ? '0 : noise - step[POWER_W-1:0];
   endfunction

   function automatic void absorb_sample(logic signed [SAMPLE_W-1:0] i_s,
                                         logic signed [SAMPLE_W-1:0] q_s,
                                         logic last);
      longint           si;
      longint           sq;
      logic [63:0]      total;
      logic [63:0]      mean;
      logic [POWER_W-1:0] power;
      squelch_verdict_t v;
      si    = i_s;
      sq    = q_s;
      total = 64'(sum_q) + 64'(si * si + sq * sq);
      sum_q = (total > SUM_LIMIT) ? SUM_LIMIT[SUM_W-1:0] : total[SUM_W-1:0];
      count_q++;
      if (!last && count_q < MAX_BLOCK) return;
      mean  = 64'(sum_q) / 64'(count_q);
      power = (mean > 64'hFFFF_FFFF) ? '1 : mean[POWER_W-1:0];
      v = '0;
      v.block_power  = power;
      v.squelch_open = (64'(power) * 64'd16) > (64'(floor_q) * 64'(ratio_q));
      if (v.squelch_open) begin
         dirty_q = 1'b1;
      end else begin
         floor_q       = track_floor(floor_q, power, alpha_q);
         v.modem_reset = dirty_q;
         dirty_q       = 1'b0;
      end
      v.noise_floor = floor_q;
      sum_q   = '0;
      count_q = 0;
      verdict_q.push_back(v);
   endfunction

   task automatic check_field(string name, logic [POWER_W-1:0] want, logic [POWER_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      squelch_verdict_t want;
      if (reset) begin
         ratio_q = RATIO_RESET;
         alpha_q = ALPHA_RESET;
         floor_q = FLOOR_RESET;
         sum_q   = '0;
         count_q = 0;
         dirty_q = 1'b0;
         verdict_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               REG_SQUELCH_RATIO:     ratio_q = csr_ch.wdata[RATIO_W-1:0];
               REG_NOISE_ALPHA:       alpha_q = csr_ch.wdata[ALPHA_W-1:0];
               REG_NOISE_FLOOR_START: floor_q = csr_ch.wdata[POWER_W-1:0];
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            absorb_sample(req_ch.i_sample, req_ch.q_sample, req_ch.last_of_block);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (verdict_q.size() == 0) begin
               $error("unexpected result: block_power %0d, noise_floor %0d",
                      rsp_ch.block_power, rsp_ch.noise_floor);
               fail_count++;
            end else begin
               want = verdict_q.pop_front();
               check_field("squelch_open", 32'(want.squelch_open), 32'(rsp_ch.squelch_open));
               check_field("modem_reset", 32'(want.modem_reset), 32'(rsp_ch.modem_reset));
               check_field("block_power", want.block_power, rsp_ch.block_power);
               check_field("noise_floor", want.noise_floor, rsp_ch.noise_floor);
            end
         end
      end
      pending = verdict_q.size();
   end

endmodule

/* tb/adaptive_power_squelch_tb.sv */
`timescale 1ns / 1ps
// Top of the adaptive power squelch testbench: clock, reset, sample and register
// stimulus, result draining, watchdog and verdict. Depends on aps_pkg, aps_if,
// aps_checker and the adaptive_power_squelch design.

module adaptive_power_squelch_tb;

   import aps_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   localparam int RANDOM_ITEMS = 1350;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 64;
   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam int HOLD_AT      = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   quiet_cycles;
   bit   req_steady;
   bit   rsp_steady;

   aps_req_if req_ch ();
   aps_rsp_if rsp_ch ();
   aps_csr_if csr_ch ();

   adaptive_power_squelch uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   aps_checker squelch_check (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data,
                            bit keep_valid = 1'b0);
      csr_ch.valid     <= 1'b1;
      csr_ch.reg_index <= idx;
      csr_ch.wdata     <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      if (!keep_valid) csr_ch.valid <= 1'b0;
   endtask

   task automatic apply_settings(logic [RATIO_W-1:0] ratio, logic [ALPHA_W-1:0] alpha,
                                 logic [POWER_W-1:0] floor_start);
      write_reg(REG_SQUELCH_RATIO, 32'(ratio), 1'b1);
      write_reg(REG_NOISE_ALPHA, 32'(alpha), 1'b1);
      write_reg(REG_NOISE_FLOOR_START, floor_start);
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] i_s, logic signed [SAMPLE_W-1:0] q_s,
                              logic last);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.i_sample      <= i_s;
      req_ch.q_sample      <= q_s;
      req_ch.last_of_block <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_component(int depth);
      if (depth >= SAMPLE_W) return SAMPLE_W'($urandom);
      return SAMPLE_W'(int'($urandom_range(0, (2 << depth) - 1)) - (1 << depth));
   endfunction

   task automatic send_block(int len, int depth);
      if ($urandom_range(0, 7) == 0) req_steady = !req_steady;
      for (int n = 1; n <= len; n++)
         send_sample(draw_component(depth), draw_component(depth), n == len);
   endtask

   // drop valid, wait out every result, then let the block go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : rsp_drain
      int stall;
      int taken;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         stall = rsp_steady ? 0 : $urandom_range(0, 3);
         if (taken == HOLD_AT) stall = LONG_HOLD;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         taken++;
         if ($urandom_range(0, 7) == 0) rsp_steady = !rsp_steady;
      end
   end

   initial begin : stimulus
      int sent;
      int len;
      int depth;
      req_ch.valid         = 1'b0;
      req_ch.i_sample      = '0;
      req_ch.q_sample      = '0;
      req_ch.last_of_block = 1'b0;
      rsp_ch.ready         = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.reg_index     = '0;
      csr_ch.wdata         = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(-16'sd32768, -16'sd32768, 1'b1);
      send_sample(16'sd0, 16'sd0, 1'b1);
      send_sample(16'sd32767, -16'sd32768, 1'b0);
      send_sample(-16'sd32768, 16'sd32767, 1'b1);
      send_sample(16'sd1, -16'sd1, 1'b0);
      send_sample(16'sd0, 16'sd1, 1'b0);
      send_sample(-16'sd1, 16'sd0, 1'b1);
      send_sample(16'sd32767, 16'sd32767, 1'b1);
      send_sample(-16'sd1, -16'sd1, 1'b1);
      settle();

      // zero floor: silence holds it, any power opens
      write_reg(REG_NOISE_FLOOR_START, '0, 1'b1);
      write_reg(REG_UNMAPPED, $urandom);
      send_sample(16'sd0, 16'sd0, 1'b1);
      send_sample(16'sd1, 16'sd0, 1'b1);
      send_sample(16'sd0, 16'sd0, 1'b1);
      settle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: apply_settings(RATIO_RESET, ALPHA_RESET, FLOOR_RESET);
            1: apply_settings('0, '0, '0);
            2: apply_settings('1, '1, 32'h8000_0000);
            3: apply_settings(8'd16, '1, 32'd1000);
            default: apply_settings(RATIO_W'($urandom_range(0, 255)),
                                    ALPHA_W'($urandom_range(0, 65535)),
                                    ($urandom_range(0, 3) == 0)
                                       ? $urandom_range(0, 32'h8000_0000)
                                       : $urandom_range(0, 1 << 18));
         endcase
         sent = 0;
         while (sent < RANDOM_ITEMS / PHASES) begin
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
            depth = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 9) : $urandom_range(10, 16);
            send_block(len, depth);
            sent += len;
         end
         settle();
      end

      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
